// ===== hdl/gnf_pkg.sv =====
`timescale 1ns / 1ps
package gnf_pkg;
  localparam int MAX_GROUP_ELEMS_DEF = 1024;
  localparam int MAX_CHANNELS_DEF = 1024;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CPG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CCOUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPS = 2'd3;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       command;
    logic [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] normalized;
    logic [15:0] group_mean;
    logic [15:0] group_stdev;
    logic [9:0]  group_number;
    logic        last_in_group;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD_WR, S_MEAN, S_VAR_RD, S_VAR_ACC, S_VAR_DIV, S_SQRT,
    S_RD_WAIT, S_RD_DIV, S_OUT
  } state_t;

  // start request to the shared divider
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

// ===== hdl/gnf_stream_if.sv =====
`timescale 1ns / 1ps
interface gnf_stream_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/gnf_divider.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module gnf_divider (
  input  logic              clk,
  input  logic              rst,
  input  gnf_pkg::div_req_t req,
  output gnf_pkg::div_rsp_t rsp
);
  import gnf_pkg::*;
  logic [47:0] quo;
  logic [32:0] rem;
  logic [31:0] den;
  logic [5:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  always_comb begin
    trial = {rem[31:0], quo[47]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
        count <= 6'd47;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[47]};
          quo <= {quo[46:0], 1'b0};
        end
        if (count == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 6'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;
  assign rsp.rem = rem[31:0];
endmodule

// ===== hdl/gnf_sqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit square root of a 33-bit value, rounded to nearest, saturated.
module gnf_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] value,
  output logic        done,
  output logic [15:0] root
);
  import gnf_pkg::*;
  logic [33:0] v;
  logic [33:0] res;
  logic [33:0] bitv;
  logic        busy;
  logic [33:0] r_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v <= {1'b0, value};
        res <= '0;
        bitv <= 34'h1_0000_0000;
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (v >= res + bitv) begin
            v <= v - (res + bitv);
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

  // v now holds value - r*r
  always_comb begin
    r_fin = (v > res) ? res + 34'd1 : res;
    root = (r_fin > 34'd65535) ? 16'hFFFF : r_fin[15:0];
  end
endmodule

// ===== hdl/group_normalization_forward.sv =====
`timescale 1ns / 1ps
// Load: each sample is written in S_IDLE and counted in S_LOAD_WR. Group end:
// mean divide, variance pass (S_VAR_RD, S_VAR_ACC per element) plus a divide,
// square root. Read: S_RD_WAIT, bit-serial divide in S_RD_DIV (skipped at zero stdev), then S_OUT.
// The sample memory is not cleared; synchronous reset clears all control
// state, statistics and configuration to their defaults.
module group_normalization_forward #(
  parameter int MAX_GROUP_ELEMS = gnf_pkg::MAX_GROUP_ELEMS_DEF,
  parameter int MAX_CHANNELS = gnf_pkg::MAX_CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst,
  gnf_stream_if.sink   in_ch,
  gnf_stream_if.source out_ch,
  input  logic                           cfg_we,
  input  logic [gnf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gnf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gnf_pkg::*;
  localparam int AW = $clog2(MAX_GROUP_ELEMS);
  localparam int CW = $clog2(MAX_GROUP_ELEMS + 1);
  localparam int SUM_W = AW + 18;

  logic [10:0] cpg, plane, ccount;
  logic [15:0] epsilon;
  state_t state, state_next;
  logic [15:0] mem [MAX_GROUP_ELEMS];
  logic [15:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] fill_count, read_pointer, scan;
  logic          readout_phase;
  logic [9:0]    group_counter;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [15:0] mean_value;
  logic [15:0]   stdev_value;
  logic [47:0]   sumsq;
  logic signed [16:0] diff;
  logic [33:0]   sq;
  in_item_t      item;
  out_item_t     res;
  out_item_t     status_res;
  logic          out_valid;
  logic          neg;
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic          sq_start, sq_done;
  logic [15:0]   sq_root;
  logic [32:0]   varv;

  // group length, clamped
  logic [10:0] cpg_e, cc_e, pl_e;
  logic [20:0] start_ch;
  logic [10:0] members;
  logic [21:0] len_raw;
  logic [CW-1:0] len;
  always_comb begin
    cpg_e = (cpg == 0) ? 11'd1 : ((int'(cpg) > MAX_CHANNELS) ? 11'(MAX_CHANNELS) : cpg);
    cc_e = (ccount == 0) ? 11'd1 :
           ((int'(ccount) > MAX_CHANNELS) ? 11'(MAX_CHANNELS) : ccount);
    pl_e = (plane == 0) ? 11'd1 : (plane > 11'd1024 ? 11'd1024 : plane);
    start_ch = 21'(group_counter) * 21'(cpg_e);
    members = cpg_e;
    if (start_ch < 21'(cc_e) && (21'(cc_e) - start_ch) < 21'(cpg_e))
      members = 11'(21'(cc_e) - start_ch);
    len_raw = 22'(members) * 22'(pl_e);
    len = (len_raw > 22'(MAX_GROUP_ELEMS)) ? CW'(MAX_GROUP_ELEMS) : CW'(len_raw);
  end
  // group count via the divider is avoided: compare running start instead
  logic wrap;
  assign wrap = (21'(group_counter) + 21'd1) * 21'(cpg_e) >= 21'(cc_e);

  assign item = in_item_t'(in_ch.payload);

  // status-only result for a refused load or a read with nothing buffered
  always_comb begin
    status_res = '0;
    status_res.group_number = group_counter;
    status_res.status = (item.command == CMD_LOAD) ? ST_REFUSED : ST_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpg <= 11'd1; plane <= 11'd1; ccount <= 11'd1; epsilon <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CPG: cpg <= cfg_data[10:0];
        REG_PLANE: plane <= cfg_data[10:0];
        REG_CCOUNT: ccount <= cfg_data[10:0];
        REG_EPS: epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= item.sample;
    rdata <= mem[raddr];
  end

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  wire acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = res;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (acc) begin
        if (item.command == CMD_LOAD && !readout_phase) state_next = S_LOAD_WR;
        else if (item.command == CMD_READ && readout_phase) state_next = S_RD_WAIT;
      end
      S_LOAD_WR: state_next = (fill_count + 1 >= len) ? S_MEAN : S_IDLE;
      S_MEAN: if (drsp.done) state_next = S_VAR_RD;
      S_VAR_RD: state_next = S_VAR_ACC;
      S_VAR_ACC: state_next = (scan == fill_count) ? S_VAR_DIV : S_VAR_RD;
      S_VAR_DIV: if (drsp.done) state_next = S_SQRT;
      S_SQRT: if (sq_done) state_next = S_IDLE;
      S_RD_WAIT: state_next = (stdev_value == 0) ? S_OUT : S_RD_DIV;
      S_RD_DIV: if (drsp.done) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory and unit controls
  always_comb begin
    we = 1'b0;
    waddr = fill_count[AW-1:0];
    raddr = scan[AW-1:0];
    dreq = '0;
    sq_start = 1'b0;
    diff = 17'(signed'(rdata)) - 17'(mean_value);
    sq = 34'(diff * diff);
    varv = 33'(sumsq) + 33'(epsilon);
    case (state)
      S_IDLE: begin
        we = acc && item.command == CMD_LOAD && !readout_phase;
        raddr = read_pointer[AW-1:0];
      end
      S_LOAD_WR: if (fill_count + 1 >= len) begin
        dreq.start = 1'b1;
        dreq.num = running_sum[SUM_W-1] ? 48'(-running_sum) : 48'(running_sum);
        dreq.num = dreq.num + 48'((fill_count + 1) >> 1);
        dreq.den = 32'(fill_count + 1);
      end
      S_VAR_ACC: if (scan == fill_count) begin
        dreq.start = 1'b1;
        dreq.num = sumsq + 48'(sq);
        dreq.den = 32'(fill_count + 1);
      end
      S_VAR_DIV: sq_start = drsp.done;
      S_RD_WAIT: if (stdev_value != 0) begin
        dreq.start = 1'b1;
        dreq.num = diff[16] ? 48'(-diff) << 8 : 48'(diff) << 8;
        dreq.num = dreq.num + 48'(stdev_value >> 1);
        dreq.den = 32'(stdev_value);
      end
      default: ;
    endcase
    if (state == S_VAR_DIV) varv = 33'(drsp.quo) + 33'(epsilon);
  end

  gnf_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  gnf_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .value(varv),
                   .done(sq_done), .root(sq_root));

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_count <= '0; read_pointer <= '0; readout_phase <= 1'b0;
      group_counter <= '0; running_sum <= '0; mean_value <= '0;
      stdev_value <= '0; out_valid <= 1'b0; scan <= '0; sumsq <= '0;
      neg <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (acc) begin
          if (item.command == CMD_LOAD && readout_phase) begin
            res <= status_res; out_valid <= 1'b1;
          end else if (item.command == CMD_READ && !readout_phase) begin
            res <= status_res; out_valid <= 1'b1;
          end else if (item.command == CMD_LOAD) begin
            running_sum <= running_sum + SUM_W'(signed'(item.sample));
          end
        end
        S_LOAD_WR: begin
          neg <= running_sum[SUM_W-1];
          if (!(fill_count + 1 >= len)) fill_count <= fill_count + 1;
        end
        S_MEAN: if (drsp.done) begin
          mean_value <= neg ? -16'(drsp.quo) : 16'(drsp.quo);
          scan <= '0; sumsq <= '0;
        end
        S_VAR_ACC: begin
          sumsq <= sumsq + 48'(sq);
          scan <= scan + 1;
        end
        S_SQRT: if (sq_done) begin
          stdev_value <= sq_root;
          readout_phase <= 1'b1;
          read_pointer <= '0;
        end
        S_RD_WAIT: begin
          neg <= diff[16];
          res.group_mean <= mean_value;
          res.group_stdev <= stdev_value;
          res.group_number <= group_counter;
          res.last_in_group <= (read_pointer + 1 >= len);
          res.status <= ST_OK;
          if (stdev_value == 0)
            res.normalized <= (diff == 0) ? 16'd0 : (diff[16] ? 16'h8000 : 16'h7FFF);
        end
        S_RD_DIV: if (drsp.done) begin
          if (neg) res.normalized <= (drsp.quo > 48'd32768) ? 16'h8000 : -16'(drsp.quo);
          else res.normalized <= (drsp.quo > 48'd32767) ? 16'h7FFF : 16'(drsp.quo);
        end
        S_OUT: begin
          out_valid <= 1'b1;
          if (read_pointer + 1 >= len) begin
            readout_phase <= 1'b0; fill_count <= '0; read_pointer <= '0;
            running_sum <= '0;
            group_counter <= wrap ? 10'd0 : group_counter + 10'd1;
          end else begin
            read_pointer <= read_pointer + 1;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_we_in_readout: assert property (@(posedge clk) disable iff (rst)
    readout_phase |-> !we) else $error("write during readout");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ch.ready) else $error("accept while result pending");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !acc) else $error("accept while busy");
endmodule
